// ===== hw/rtl/aiger_and_gate_delta_encoder_defines.svh =====
// assertion macros used by the checker
`ifndef AIGER_AND_GATE_DELTA_ENCODER_DEFINES_SVH
`define AIGER_AND_GATE_DELTA_ENCODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AAGDE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, disabled in reset
`define AAGDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/aagde_pkg.sv =====
package aagde_pkg;

  localparam int unsigned VarW   = 31;
  localparam int unsigned LitW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 7;

  typedef struct packed {
    logic [LitW-1:0] gate_delta;
    logic [LitW-1:0] fanin_delta;
  } delta_pair_t;

  typedef enum logic [1:0] {
    StIdle,
    StGateDelta,
    StFaninDelta
  } back_state_e;

endpackage

// ===== hw/rtl/aagde_front.sv =====
module aagde_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [aagde_pkg::VarW-1:0]  gate_var_i,
  input  logic [aagde_pkg::VarW-1:0]  first_var_i,
  input  logic                        first_plain_i,
  input  logic [aagde_pkg::VarW-1:0]  second_var_i,
  input  logic                        second_plain_i,
  input  logic                        full_i,
  output logic                        push_o,
  output aagde_pkg::delta_pair_t      pair_o
);

  logic [aagde_pkg::LitW-1:0] lit_gate;
  logic [aagde_pkg::LitW-1:0] lit_first;
  logic [aagde_pkg::LitW-1:0] lit_second;
  logic [aagde_pkg::LitW:0]   diff_fs;
  logic [aagde_pkg::LitW-1:0] diff_sf;
  logic [aagde_pkg::LitW-1:0] gate_m_first;
  logic [aagde_pkg::LitW-1:0] gate_m_second;
  logic                       first_lt;

  // literal: twice the variable, low bit set when inverted
  assign lit_gate   = {gate_var_i, 1'b0};
  assign lit_first  = {first_var_i, ~first_plain_i};
  assign lit_second = {second_var_i, ~second_plain_i};

  // all differences side by side, the borrow picks the larger fanin
  assign diff_fs       = {1'b0, lit_first} - {1'b0, lit_second};
  assign diff_sf       = lit_second - lit_first;
  assign gate_m_first  = lit_gate - lit_first;
  assign gate_m_second = lit_gate - lit_second;
  assign first_lt      = diff_fs[aagde_pkg::LitW];

  assign pair_o.gate_delta  = first_lt ? gate_m_second : gate_m_first;
  assign pair_o.fanin_delta = first_lt ? diff_sf : diff_fs[aagde_pkg::LitW-1:0];

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

endmodule

// ===== hw/rtl/aagde_fifo.sv =====
module aagde_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  aagde_pkg::delta_pair_t data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output aagde_pkg::delta_pair_t data_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  aagde_pkg::delta_pair_t entries_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/aagde_back.sv =====
module aagde_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  aagde_pkg::delta_pair_t        pair_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aagde_pkg::ByteW-1:0]   out_byte_o,
  output logic                          delta_end_o,
  output logic                          gate_end_o
);

  localparam int unsigned LitW   = aagde_pkg::LitW;
  localparam int unsigned DigitW = aagde_pkg::DigitW;
  localparam int unsigned ByteW  = aagde_pkg::ByteW;

  aagde_pkg::back_state_e state_q, state_d;
  logic [LitW-1:0]  shift_q, shift_d;
  logic [LitW-1:0]  fanin_q, fanin_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             delta_end_q, delta_end_d;
  logic             gate_end_q, gate_end_d;

  logic             out_free;
  logic             emit;
  logic [LitW-1:0]  cur;
  logic             more;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign cur      = (state_q == aagde_pkg::StIdle) ? pair_i.gate_delta : shift_q;
  assign more     = |cur[LitW-1:DigitW];

  always_comb begin
    case (state_q)
      aagde_pkg::StIdle:       emit = valid_i & out_free;
      aagde_pkg::StGateDelta:  emit = out_free;
      aagde_pkg::StFaninDelta: emit = out_free;
      default:                 emit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (emit) begin
      case (state_q)
        aagde_pkg::StIdle,
        aagde_pkg::StGateDelta: begin
          state_d = more ? aagde_pkg::StGateDelta : aagde_pkg::StFaninDelta;
        end
        aagde_pkg::StFaninDelta: begin
          state_d = more ? aagde_pkg::StFaninDelta : aagde_pkg::StIdle;
        end
        default: state_d = aagde_pkg::StIdle;
      endcase
    end
  end

  // datapath and output word
  always_comb begin
    pop_o       = 1'b0;
    shift_d     = shift_q;
    fanin_d     = fanin_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_byte_d  = out_byte_q;
    delta_end_d = delta_end_q;
    gate_end_d  = gate_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = {more, cur[DigitW-1:0]};
      delta_end_d = ~more;
      gate_end_d  = ~more & (state_q == aagde_pkg::StFaninDelta);
      shift_d     = cur >> DigitW;
      case (state_q)
        aagde_pkg::StIdle: begin
          pop_o   = 1'b1;
          fanin_d = pair_i.fanin_delta;
          if (!more) begin
            shift_d = pair_i.fanin_delta;
          end
        end
        aagde_pkg::StGateDelta: begin
          if (!more) begin
            shift_d = fanin_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aagde_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q     <= shift_d;
    fanin_q     <= fanin_d;
    out_byte_q  <= out_byte_d;
    delta_end_q <= delta_end_d;
    gate_end_q  <= gate_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign delta_end_o = delta_end_q;
  assign gate_end_o  = gate_end_q;

endmodule

// ===== hw/rtl/aiger_and_gate_delta_encoder.sv =====
// AND gate delta encoder for the binary AIGER format. Each input word is one
// AND gate (its variable and the variables and polarities of its two fanins);
// the block forms the literals, orders the fanins, and emits the two deltas
// (gate minus larger fanin, larger minus smaller fanin, modulo 2^32) as
// 7-bit little-endian varints, one byte per output word, delta_end on the
// last byte of each delta and gate_end on the last byte of the gate. The
// front end computes both deltas in the cycle a gate is taken and writes
// them into a queue of QUEUE_DEPTH entries (at least 2); the back-end byte
// serialiser drains it at one byte per cycle while the output is not stalled;
// a gate has 2 bytes when both deltas are below 128, up to 10 when both need
// five bytes. With the queue empty and the serialiser idle, a gate taken is
// written into the queue, then its first byte is registered into the output.
// There is no configuration and no state across gates.
module aiger_and_gate_delta_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [aagde_pkg::VarW-1:0]  gate_var_i,
  input  logic [aagde_pkg::VarW-1:0]  first_var_i,
  input  logic                        first_plain_i,
  input  logic [aagde_pkg::VarW-1:0]  second_var_i,
  input  logic                        second_plain_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [aagde_pkg::ByteW-1:0] out_byte_o,
  output logic                        delta_end_o,
  output logic                        gate_end_o
);

  logic                   push, full, pop, queue_valid;
  aagde_pkg::delta_pair_t push_pair, head_pair;

  aagde_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .gate_var_i     (gate_var_i),
    .first_var_i    (first_var_i),
    .first_plain_i  (first_plain_i),
    .second_var_i   (second_var_i),
    .second_plain_i (second_plain_i),
    .full_i         (full),
    .push_o         (push),
    .pair_o         (push_pair)
  );

  aagde_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_pair),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (head_pair)
  );

  aagde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .pair_i      (head_pair),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .delta_end_o (delta_end_o),
    .gate_end_o  (gate_end_o)
  );

endmodule

// ===== hw/rtl/aagde_checker.sv =====
`include "aiger_and_gate_delta_encoder_defines.svh"

module aagde_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [aagde_pkg::ByteW-1:0] out_byte_o,
  input logic                        delta_end_o,
  input logic                        gate_end_o
);

  // a stalled output word holds
  `AAGDE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_byte_o) && $stable(delta_end_o) && $stable(gate_end_o))
  // a gate ends only where a delta ends
  `AAGDE_ASSERT_IMPLIES(a_gate_end_delta, clk_i, rst_ni, out_valid_o && gate_end_o, delta_end_o)
  // the continuation bit is clear exactly on the last byte of a delta
  `AAGDE_ASSERT_IMPLIES(a_last_no_more, clk_i, rst_ni, out_valid_o && delta_end_o,
    !out_byte_o[aagde_pkg::ByteW-1])
  `AAGDE_ASSERT_IMPLIES(a_more_not_last, clk_i, rst_ni, out_valid_o && !delta_end_o,
    out_byte_o[aagde_pkg::ByteW-1])

endmodule

bind aiger_and_gate_delta_encoder aagde_checker u_checker (.*);
